FILE: design/frame_pool_priority_discard_defines.svh
// assertion macros for the frame pool block
`ifndef FRAME_POOL_PRIORITY_DISCARD_DEFINES_SVH
`define FRAME_POOL_PRIORITY_DISCARD_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FPD_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FPD_ASSERT(label, clk, rst_n, prop)
`define FPD_ASSERT_RST(label, clk, prop)
`endif
`endif

FILE: design/fpd_pkg.sv
// shared types and constants for the frame pool block
package fpd_pkg;
    localparam int NUM_SLOTS = 16;
    localparam int SW = 4;

    localparam logic [2:0] OP_ACQUIRE = 3'd0;
    localparam logic [2:0] OP_APPEND  = 3'd1;
    localparam logic [2:0] OP_NEXTWR  = 3'd2;
    localparam logic [2:0] OP_MARK    = 3'd3;
    localparam logic [2:0] OP_RESET   = 3'd4;

    localparam logic [1:0] AT_EMPTY   = 2'd0;
    localparam logic [1:0] AT_WAITING = 2'd1;
    localparam logic [1:0] AT_HELD    = 2'd2;

    localparam logic [2:0] RANK_NONE = 3'd5;

    typedef struct packed {
        logic start;
        logic [2:0] op;
        logic step;
        logic finish;
    } fpd_cmd_t;

    typedef struct packed {
        logic walk_done;
    } fpd_stat_t;

    function automatic logic [2:0] rank_of(input logic [3:0] f);
        logic nw;
        nw = f[1] & ~f[2];
        if (f[0])
            return nw ? 3'd4 : 3'd2;
        return nw ? 3'd3 : 3'd1;
    endfunction
endpackage

FILE: design/fpd_ctrl.sv
// controller state machine for the frame pool block
module fpd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       in_op,
    output logic             out_valid,
    input  logic             out_stall,
    output fpd_pkg::fpd_cmd_t cmd,
    input  fpd_pkg::fpd_stat_t stat
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cmd = '0;
        cmd.op = op_reg;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    cmd.op = in_op;
                    op_next = in_op;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
                else
                    cmd.step = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: design/fpd_datapath.sv
// slot lists, flags, counters and list walker for the frame pool block
`include "frame_pool_priority_discard_defines.svh"
module fpd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  fpd_pkg::fpd_cmd_t cmd,
    output fpd_pkg::fpd_stat_t stat,
    input  logic [3:0]        in_slot,
    input  logic              in_bright,
    input  logic              in_writable,
    output logic              status,
    output logic [3:0]        slot_out,
    output logic              from_waiting,
    output logic [4:0]        waiting_count,
    output logic [4:0]        unwritten_count,
    output logic [31:0]       writable_total,
    output logic [31:0]       dropped_total
);
    localparam int N = fpd_pkg::NUM_SLOTS;
    typedef logic [fpd_pkg::SW-1:0] sl_t;

    sl_t        nxt_reg [N];
    sl_t        prv_reg [N];
    logic [3:0] flg_reg [N];
    logic [1:0] plc_reg [N];
    sl_t        fifo_reg [N];
    sl_t        ehead_reg;
    logic [4:0] elen_reg;
    sl_t        whead_reg, wtail_reg;
    logic [4:0] wlen_reg;
    sl_t        wpos_reg;
    logic       wvalid_reg;
    logic [4:0] unw_reg;
    logic [31:0] wrt_reg, drp_reg;

    // walk state
    sl_t        cur_reg;
    logic [4:0] n_reg;
    logic [4:0] total_reg;
    logic       done_reg;
    logic       found_reg;
    logic [2:0] best_reg;
    sl_t        pick_reg;
    logic       st_reg;
    sl_t        so_reg;
    logic       fw_reg;
    logic [3:0] rslot_reg;
    logic       rbright_reg, rwr_reg;

    logic [3:0] fc;
    logic       nw_cur;
    logic [2:0] rk;
    sl_t        etail;

    assign fc = flg_reg[cur_reg];
    assign nw_cur = fc[1] & ~fc[2];
    assign rk = fpd_pkg::rank_of(fc);
    assign etail = ehead_reg + elen_reg[fpd_pkg::SW-1:0];
    assign stat.walk_done = done_reg;

    assign status = st_reg;
    assign slot_out = so_reg;
    assign from_waiting = fw_reg;
    assign waiting_count = wlen_reg;
    assign unwritten_count = unw_reg;
    assign writable_total = wrt_reg;
    assign dropped_total = drp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                nxt_reg[i] <= '0;
                prv_reg[i] <= '0;
                flg_reg[i] <= '0;
                plc_reg[i] <= fpd_pkg::AT_EMPTY;
                fifo_reg[i] <= sl_t'(i);
            end
            ehead_reg <= '0;
            elen_reg <= 5'(N);
            whead_reg <= '0;
            wtail_reg <= '0;
            wlen_reg <= '0;
            wpos_reg <= '0;
            wvalid_reg <= 1'b0;
            unw_reg <= '0;
            wrt_reg <= '0;
            drp_reg <= '0;
            cur_reg <= '0;
            n_reg <= '0;
            total_reg <= '0;
            done_reg <= 1'b0;
            found_reg <= 1'b0;
            best_reg <= fpd_pkg::RANK_NONE;
            pick_reg <= '0;
            st_reg <= 1'b1;
            so_reg <= '0;
            fw_reg <= 1'b0;
            rslot_reg <= '0;
            rbright_reg <= 1'b0;
            rwr_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            st_reg <= 1'b1;
            so_reg <= '0;
            fw_reg <= 1'b0;
            done_reg <= 1'b0;
            found_reg <= 1'b0;
            best_reg <= fpd_pkg::RANK_NONE;
            n_reg <= '0;
            total_reg <= wlen_reg;
            cur_reg <= whead_reg;
            rslot_reg <= in_slot;
            rbright_reg <= in_bright;
            rwr_reg <= in_writable;
            case (cmd.op)
                fpd_pkg::OP_ACQUIRE:
                begin
                    if (elen_reg != 5'd0)
                    begin
                        flg_reg[fifo_reg[ehead_reg]] <= '0;
                        plc_reg[fifo_reg[ehead_reg]] <= fpd_pkg::AT_HELD;
                        so_reg <= fifo_reg[ehead_reg];
                        st_reg <= 1'b0;
                        ehead_reg <= ehead_reg + 1'b1;
                        elen_reg <= elen_reg - 1'b1;
                        done_reg <= 1'b1;
                    end
                end
                fpd_pkg::OP_NEXTWR:
                begin
                    if (wvalid_reg)
                    begin
                        flg_reg[wpos_reg][3] <= 1'b0;
                        cur_reg <= wpos_reg;
                    end
                    else if (wlen_reg == 5'd0)
                        done_reg <= 1'b1;
                    else
                    begin
                        wpos_reg <= whead_reg;
                        wvalid_reg <= 1'b1;
                    end
                end
                fpd_pkg::OP_RESET:
                begin
                    if (wvalid_reg && !flg_reg[wpos_reg][3])
                        wvalid_reg <= 1'b0;
                    wrt_reg <= '0;
                    unw_reg <= '0;
                    drp_reg <= '0;
                end
                default: ;
            endcase
        end
        else if (cmd.step)
        begin
            case (cmd.op)
                fpd_pkg::OP_ACQUIRE:
                begin
                    if (n_reg == total_reg || n_reg == 5'(N))
                        done_reg <= 1'b1;
                    else
                    begin
                        if (!fc[3] && rk < best_reg)
                        begin
                            best_reg <= rk;
                            pick_reg <= cur_reg;
                            found_reg <= 1'b1;
                        end
                        if (!fc[3] && rk == 3'd1)
                            done_reg <= 1'b1;
                        cur_reg <= nxt_reg[cur_reg];
                        n_reg <= n_reg + 1'b1;
                    end
                end
                fpd_pkg::OP_NEXTWR:
                begin
                    if (nw_cur)
                    begin
                        flg_reg[cur_reg][3] <= 1'b1;
                        st_reg <= 1'b0;
                        so_reg <= cur_reg;
                        wpos_reg <= cur_reg;
                        done_reg <= 1'b1;
                    end
                    else if (cur_reg == wtail_reg || n_reg == 5'(N - 1))
                    begin
                        wpos_reg <= cur_reg;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        cur_reg <= nxt_reg[cur_reg];
                        n_reg <= n_reg + 1'b1;
                    end
                end
                fpd_pkg::OP_RESET:
                begin
                    if (n_reg == total_reg || n_reg == 5'(N))
                    begin
                        st_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        cur_reg <= nxt_reg[cur_reg];
                        n_reg <= n_reg + 1'b1;
                        if (!fc[3])
                        begin
                            if (cur_reg == wtail_reg)
                                wtail_reg <= prv_reg[cur_reg];
                            else
                                prv_reg[nxt_reg[cur_reg]] <= prv_reg[cur_reg];
                            if (cur_reg == whead_reg)
                                whead_reg <= nxt_reg[cur_reg];
                            else
                                nxt_reg[prv_reg[cur_reg]] <= nxt_reg[cur_reg];
                            nxt_reg[cur_reg] <= '0;
                            prv_reg[cur_reg] <= '0;
                            wlen_reg <= wlen_reg - 1'b1;
                            fifo_reg[etail] <= cur_reg;
                            elen_reg <= elen_reg + 1'b1;
                            plc_reg[cur_reg] <= fpd_pkg::AT_EMPTY;
                        end
                    end
                end
                fpd_pkg::OP_APPEND:
                begin
                    done_reg <= 1'b1;
                    if (plc_reg[rslot_reg] == fpd_pkg::AT_HELD)
                    begin
                        flg_reg[rslot_reg] <= {2'b00, rwr_reg, rbright_reg};
                        if (rwr_reg)
                        begin
                            wrt_reg <= wrt_reg + 1'b1;
                            unw_reg <= unw_reg + 1'b1;
                        end
                        if (wlen_reg == 5'd0)
                            whead_reg <= rslot_reg;
                        else
                        begin
                            nxt_reg[wtail_reg] <= rslot_reg;
                            prv_reg[rslot_reg] <= wtail_reg;
                        end
                        wtail_reg <= rslot_reg;
                        wlen_reg <= wlen_reg + 1'b1;
                        plc_reg[rslot_reg] <= fpd_pkg::AT_WAITING;
                        st_reg <= 1'b0;
                        so_reg <= rslot_reg;
                    end
                end
                fpd_pkg::OP_MARK:
                begin
                    done_reg <= 1'b1;
                    if (wvalid_reg)
                    begin
                        if (flg_reg[wpos_reg][1] && !flg_reg[wpos_reg][2])
                        begin
                            if (unw_reg != 5'd0)
                                unw_reg <= unw_reg - 1'b1;
                            flg_reg[wpos_reg][2] <= 1'b1;
                        end
                        st_reg <= 1'b0;
                        so_reg <= wpos_reg;
                    end
                end
                default: done_reg <= 1'b1;
            endcase
        end
        else if (cmd.finish && cmd.op == fpd_pkg::OP_ACQUIRE && found_reg)
        begin
            if (flg_reg[pick_reg][1] && !flg_reg[pick_reg][2])
            begin
                if (unw_reg != 5'd0)
                    unw_reg <= unw_reg - 1'b1;
                drp_reg <= drp_reg + 1'b1;
            end
            if (pick_reg == wtail_reg)
                wtail_reg <= prv_reg[pick_reg];
            else
                prv_reg[nxt_reg[pick_reg]] <= prv_reg[pick_reg];
            if (pick_reg == whead_reg)
                whead_reg <= nxt_reg[pick_reg];
            else
                nxt_reg[prv_reg[pick_reg]] <= nxt_reg[pick_reg];
            nxt_reg[pick_reg] <= '0;
            prv_reg[pick_reg] <= '0;
            wlen_reg <= wlen_reg - 1'b1;
            if (wvalid_reg && wpos_reg == pick_reg)
                wvalid_reg <= 1'b0;
            flg_reg[pick_reg] <= '0;
            plc_reg[pick_reg] <= fpd_pkg::AT_HELD;
            st_reg <= 1'b0;
            so_reg <= pick_reg;
            fw_reg <= 1'b1;
        end
    end

    `FPD_ASSERT(a_counts_bounded, clk, rst_n, (wlen_reg + elen_reg) <= 6'(N))
    `FPD_ASSERT(a_fw_means_ok, clk, rst_n, fw_reg |-> !st_reg)
    `FPD_ASSERT(a_fail_slot_zero, clk, rst_n, st_reg |-> (so_reg == '0))
endmodule

FILE: design/frame_pool_priority_discard.sv
// frame pool with priority discard: an acquire from the empty fifo, a next writable
// on an empty list, append, mark and unknown ops finish without a list walk; a list
// walk (acquire reclaim, next writable, reset) visits up to NUM_SLOTS waiting slots
// one beat in flight; the next beat is taken the cycle after the result is taken
// asynchronous active-low reset puts every slot in the empty fifo in order
// and clears counters, flags and the write pointer
module frame_pool_priority_discard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [3:0]  slot,
    input  logic        bright,
    input  logic        writable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [3:0]  slot_out,
    output logic        from_waiting,
    output logic [4:0]  waiting_count,
    output logic [4:0]  unwritten_count,
    output logic [31:0] writable_total,
    output logic [31:0] dropped_total
);
    fpd_pkg::fpd_cmd_t  cmd;
    fpd_pkg::fpd_stat_t stat;

    fpd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_op(operation), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat)
    );

    fpd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_slot(slot), .in_bright(bright), .in_writable(writable),
        .status(status), .slot_out(slot_out), .from_waiting(from_waiting),
        .waiting_count(waiting_count), .unwritten_count(unwritten_count),
        .writable_total(writable_total), .dropped_total(dropped_total)
    );
endmodule

FILE: tb/sv/tb.sv
// testbench for the frame pool with priority discard: directed table, then random traffic
`timescale 1ns / 1ps

module tb;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_BAD = 3'd7;
    localparam int ITEMS = 1000;
    localparam int LIMIT = 600000;

    localparam logic [3:0] F_BRIGHT = 4'b0001;
    localparam logic [3:0] F_WRITABLE = 4'b0010;
    localparam logic [3:0] F_WRITTEN = 4'b0100;
    localparam logic [3:0] F_LOCK = 4'b1000;

    typedef struct packed {
        logic        status;
        logic [3:0]  slot_out;
        logic        from_waiting;
        logic [4:0]  waiting_count;
        logic [4:0]  unwritten_count;
        logic [31:0] writable_total;
        logic [31:0] dropped_total;
    } pool_result_t;

    typedef struct packed {
        logic [2:0]   op;
        logic [3:0]   slot;
        logic         bright;
        logic         writable;
        logic         typed;
        pool_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [3:0]  slot;
    logic        bright;
    logic        writable;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic [3:0]  slot_out;
    logic        from_waiting;
    logic [4:0]  waiting_count;
    logic [4:0]  unwritten_count;
    logic [31:0] writable_total;
    logic [31:0] dropped_total;

    frame_pool_priority_discard u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .slot(slot),
        .bright(bright),
        .writable(writable),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .slot_out(slot_out),
        .from_waiting(from_waiting),
        .waiting_count(waiting_count),
        .unwritten_count(unwritten_count),
        .writable_total(writable_total),
        .dropped_total(dropped_total)
    );

    // pool image
    logic [3:0]  nxt [fpd_pkg::NUM_SLOTS];
    logic [3:0]  prv [fpd_pkg::NUM_SLOTS];
    logic [3:0]  flg [fpd_pkg::NUM_SLOTS];
    logic [1:0]  plc [fpd_pkg::NUM_SLOTS];
    logic [3:0]  efifo [fpd_pkg::NUM_SLOTS];
    int          ehead;
    int          elen;
    logic [3:0]  whead;
    logic [3:0]  wtail;
    int          wlen;
    logic [3:0]  wpos;
    logic        wvalid;
    int          unw;
    logic [31:0] wtot;
    logic [31:0] drp;

    pool_result_t expected_results[$];
    int          errors;
    int          cycles;
    int          out_wait;
    logic        calm;

    function automatic logic needs_write(logic [3:0] s);
        return flg[s][1] && !flg[s][2];
    endfunction

    function automatic int priority_of(logic [3:0] s);
        if (flg[s][0])
            return needs_write(s) ? 4 : 2;
        return needs_write(s) ? 3 : 1;
    endfunction

    function automatic void unlink_waiting(logic [3:0] s);
        if (s == wtail)
            wtail = prv[s];
        else
            prv[nxt[s]] = prv[s];
        if (s == whead)
            whead = nxt[s];
        else
            nxt[prv[s]] = nxt[s];
        nxt[s] = '0;
        prv[s] = '0;
        wlen--;
    endfunction

    function automatic void pool_init();
        for (int i = 0; i < fpd_pkg::NUM_SLOTS; i++)
        begin
            nxt[i] = '0;
            prv[i] = '0;
            flg[i] = '0;
            plc[i] = fpd_pkg::AT_EMPTY;
            efifo[i] = 4'(i);
        end
        ehead = 0;
        elen = fpd_pkg::NUM_SLOTS;
        whead = '0;
        wtail = '0;
        wlen = 0;
        wpos = '0;
        wvalid = 1'b0;
        unw = 0;
        wtot = '0;
        drp = '0;
    endfunction

    function automatic pool_result_t pool_step(logic [2:0] op, logic [3:0] s_in,
                                               logic b_in, logic w_in);
        pool_result_t r;
        logic [3:0] cur;
        logic [3:0] pick;
        logic [3:0] nx;
        logic found;
        logic go;
        int best;
        int rk;
        int total;
        r = '0;
        r.status = 1'b1;
        if (op == fpd_pkg::OP_ACQUIRE)
        begin
            if (elen > 0)
            begin
                cur = efifo[ehead];
                ehead = (ehead + 1) % fpd_pkg::NUM_SLOTS;
                elen--;
                flg[cur] = '0;
                plc[cur] = fpd_pkg::AT_HELD;
                r.status = 1'b0;
                r.slot_out = cur;
            end
            else
            begin
                cur = whead;
                pick = '0;
                found = 1'b0;
                best = 5;
                for (int n = 0; n < wlen && n < fpd_pkg::NUM_SLOTS; n++)
                begin
                    if (!flg[cur][3])
                    begin
                        rk = priority_of(cur);
                        if (rk < best)
                        begin
                            best = rk;
                            pick = cur;
                            found = 1'b1;
                            if (rk == 1)
                                break;
                        end
                    end
                    cur = nxt[cur];
                end
                if (found)
                begin
                    if (needs_write(pick))
                    begin
                        if (unw > 0)
                            unw--;
                        drp++;
                    end
                    unlink_waiting(pick);
                    if (wvalid && wpos == pick)
                        wvalid = 1'b0;
                    flg[pick] = '0;
                    plc[pick] = fpd_pkg::AT_HELD;
                    r.status = 1'b0;
                    r.slot_out = pick;
                    r.from_waiting = 1'b1;
                end
            end
        end
        else if (op == fpd_pkg::OP_APPEND)
        begin
            if (plc[s_in] == fpd_pkg::AT_HELD)
            begin
                flg[s_in] = (b_in ? F_BRIGHT : 4'b0) | (w_in ? F_WRITABLE : 4'b0);
                if (w_in)
                begin
                    wtot++;
                    unw++;
                end
                if (wlen == 0)
                    whead = s_in;
                else
                begin
                    nxt[wtail] = s_in;
                    prv[s_in] = wtail;
                end
                wtail = s_in;
                wlen++;
                plc[s_in] = fpd_pkg::AT_WAITING;
                r.status = 1'b0;
                r.slot_out = s_in;
            end
        end
        else if (op == fpd_pkg::OP_NEXTWR)
        begin
            go = 1'b1;
            if (wvalid)
                flg[wpos] = flg[wpos] & ~F_LOCK;
            else if (wlen == 0)
                go = 1'b0;
            else
            begin
                wpos = whead;
                wvalid = 1'b1;
            end
            if (go)
            begin
                for (int n = 0; n < fpd_pkg::NUM_SLOTS; n++)
                begin
                    if (needs_write(wpos))
                    begin
                        flg[wpos] = flg[wpos] | F_LOCK;
                        r.status = 1'b0;
                        r.slot_out = wpos;
                        break;
                    end
                    if (wpos == wtail)
                        break;
                    wpos = nxt[wpos];
                end
            end
        end
        else if (op == fpd_pkg::OP_MARK)
        begin
            if (wvalid)
            begin
                if (needs_write(wpos))
                begin
                    if (unw > 0)
                        unw--;
                    flg[wpos] = flg[wpos] | F_WRITTEN;
                end
                r.status = 1'b0;
                r.slot_out = wpos;
            end
        end
        else if (op == fpd_pkg::OP_RESET)
        begin
            cur = whead;
            total = wlen;
            if (wvalid && !flg[wpos][3])
                wvalid = 1'b0;
            for (int n = 0; n < total && n < fpd_pkg::NUM_SLOTS; n++)
            begin
                nx = nxt[cur];
                if (!flg[cur][3])
                begin
                    unlink_waiting(cur);
                    efifo[(ehead + elen) % fpd_pkg::NUM_SLOTS] = cur;
                    elen++;
                    plc[cur] = fpd_pkg::AT_EMPTY;
                end
                cur = nx;
            end
            wtot = '0;
            unw = 0;
            drp = '0;
            r.status = 1'b0;
        end
        r.waiting_count = 5'(wlen);
        r.unwritten_count = 5'(unw);
        r.writable_total = wtot;
        r.dropped_total = drp;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic send_beat(logic [2:0] op, logic [3:0] s, logic b, logic w,
                             logic typed, pool_result_t typed_res);
        int gap;
        pool_result_t r;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        slot <= s;
        bright <= b;
        writable <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = pool_step(op, s, b, w);
        expected_results.push_back(typed ? typed_res : r);
    endtask

    function automatic pool_result_t mk(logic st, logic [3:0] so, int wc, int uc, int wt);
        pool_result_t r;
        r = '0;
        r.status = st;
        r.slot_out = so;
        r.waiting_count = 5'(wc);
        r.unwritten_count = 5'(uc);
        r.writable_total = 32'(wt);
        return r;
    endfunction

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check and random stall
    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result beat", 32'd1, 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (slot_out !== want.slot_out)
                        report_mismatch("slot_out", slot_out, want.slot_out);
                    if (from_waiting !== want.from_waiting)
                        report_mismatch("from_waiting", from_waiting, want.from_waiting);
                    if (waiting_count !== want.waiting_count)
                        report_mismatch("waiting_count", waiting_count, want.waiting_count);
                    if (unwritten_count !== want.unwritten_count)
                        report_mismatch("unwritten_count", unwritten_count,
                                        want.unwritten_count);
                    if (writable_total !== want.writable_total)
                        report_mismatch("writable_total", writable_total, want.writable_total);
                    if (dropped_total !== want.dropped_total)
                        report_mismatch("dropped_total", dropped_total, want.dropped_total);
                end
                out_wait = calm ? 0 : $urandom_range(0, 16);
            end
            if (out_wait > 0)
            begin
                out_stall <= 1'b1;
                out_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        int pick;
        int held[$];
        logic [2:0] op;
        logic [3:0] s;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = fpd_pkg::OP_ACQUIRE;
        slot = '0;
        bright = 1'b0;
        writable = 1'b0;
        out_stall = 1'b0;
        errors = 0;
        cycles = 0;
        out_wait = 0;
        calm = 1'b0;
        pool_init();

        rows.push_back({fpd_pkg::OP_ACQUIRE, 4'd0, 1'b0, 1'b0, 1'b1, mk(0, 0, 0, 0, 0)});
        rows.push_back({fpd_pkg::OP_APPEND, 4'd0, 1'b1, 1'b1, 1'b1, mk(0, 0, 1, 1, 1)});
        rows.push_back({fpd_pkg::OP_APPEND, 4'd0, 1'b0, 1'b1, 1'b1, mk(1, 0, 1, 1, 1)});
        rows.push_back({fpd_pkg::OP_APPEND, 4'd15, 1'b1, 1'b0, 1'b1, mk(1, 0, 1, 1, 1)});
        rows.push_back({OP_BAD, 4'd15, 1'b1, 1'b1, 1'b1, mk(1, 0, 1, 1, 1)});
        rows.push_back({fpd_pkg::OP_MARK, 4'd0, 1'b0, 1'b0, 1'b1, mk(1, 0, 1, 1, 1)});
        rows.push_back({fpd_pkg::OP_NEXTWR, 4'd0, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_MARK, 4'd0, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_NEXTWR, 4'd0, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_MARK, 4'd0, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({OP_SPARE_LO, 4'd7, 1'b0, 1'b1, 1'b0, pool_result_t'('0)});
        rows.push_back({OP_SPARE_MID, 4'd8, 1'b1, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_RESET, 4'd0, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});
        for (int i = 0; i < 5; i++)
            rows.push_back({fpd_pkg::OP_ACQUIRE, 4'd0, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_APPEND, 4'd1, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_APPEND, 4'd2, 1'b1, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_APPEND, 4'd3, 1'b0, 1'b1, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_APPEND, 4'd4, 1'b1, 1'b1, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_NEXTWR, 4'd0, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});
        rows.push_back({fpd_pkg::OP_RESET, 4'd0, 1'b0, 1'b0, 1'b0, pool_result_t'('0)});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_beat(rows[i].op, rows[i].slot, rows[i].bright, rows[i].writable,
                      rows[i].typed, rows[i].res);

        for (int i = 0; i < ITEMS; i++)
        begin
            calm = ((i / 150) % 3) == 2;
            held.delete();
            for (int k = 0; k < fpd_pkg::NUM_SLOTS; k++)
                if (plc[k] == fpd_pkg::AT_HELD)
                    held.push_back(k);
            pick = $urandom_range(0, 99);
            s = 4'($urandom_range(0, 15));
            if (pick < 35)
                op = fpd_pkg::OP_ACQUIRE;
            else if (pick < 68)
            begin
                op = fpd_pkg::OP_APPEND;
                if (held.size() > 0)
                    s = 4'(held[$urandom_range(0, held.size() - 1)]);
            end
            else if (pick < 82)
                op = fpd_pkg::OP_NEXTWR;
            else if (pick < 94)
                op = fpd_pkg::OP_MARK;
            else if (pick < 96)
                op = fpd_pkg::OP_RESET;
            else if (pick < 99)
                op = fpd_pkg::OP_APPEND;
            else
                op = 3'($urandom_range(OP_SPARE_LO, OP_BAD));
            send_beat(op, s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'b0, pool_result_t'('0));
        end
        in_valid <= 1'b0;

        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/fpd_pkg.sv
design/fpd_ctrl.sv
design/fpd_datapath.sv
design/frame_pool_priority_discard.sv
tb/sv/tb.sv
